[sv/running_stats_aggregator_defines.svh]
// Assertion macros for the running statistics aggregator.
`ifndef RUNNING_STATS_AGGREGATOR_DEFINES_SVH
`define RUNNING_STATS_AGGREGATOR_DEFINES_SVH

// Property checked on every rising clock edge, held off while reset is high.
`define RSA_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Property checked on every rising clock edge, reset included.
`define RSA_ASSERT_ANY(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

[sv/rsa_pkg.sv]
package rsa_pkg;

   // default widths
   localparam int DATA_W_DEF  = 32;
   localparam int COUNT_W_DEF = 16;

   // fixed widths of the square sum and the variance result
   localparam int SQ_W   = 64;
   localparam int VAR_W  = 63;
   localparam int FRAC_W = 8;

   // variance saturation value, also reported when variance is not valid
   localparam logic [VAR_W-1:0] VAR_MAX = '1;

   // command codes
   typedef enum logic [2:0] {
      FUNC_PUSH    = 3'd0,
      FUNC_CLR_MIN = 3'd1,
      FUNC_CLR_MAX = 3'd2,
      FUNC_CLR_SUM = 3'd3,
      FUNC_CLR_ALL = 3'd4
   } func_type;

   // sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SQR,
      ST_MEAN_PLAN,
      ST_MEAN,
      ST_MEAN_END,
      ST_VAR_PLAN,
      ST_NQ,
      ST_SS,
      ST_VAR_SETUP,
      ST_VAR_DIV,
      ST_VAR_END,
      ST_DONE
   } state_type;

   // handshake control from the top level to the sequencer
   typedef struct packed {
      logic start;
      logic ack;
   } seq_ctrl_type;

   // sequencer status back to the top level
   typedef struct packed {
      logic busy;
      logic done;
   } seq_stat_type;

endpackage

[sv/running_stats_aggregator.sv]
// Running min/max/mean/variance over signed samples. Each item carries a
// command (push or one of the clears) and returns one item with every
// statistic. req_stall stays high from the acceptance of an item until its
// result is moved into the output register.
// All multiplies and divides run one bit per cycle through a single shared
// adder of SQ_W + COUNT_WIDTH bits; the variance division, one cycle per
// dividend bit (72 + COUNT_WIDTH bits), is the largest share. A finished
// result waits in an output register, and the next item can be accepted
// while it does. variance_enable is written through the csr_ port; csr_ready
// is high only while the block is idle and no input item is offered.
`include "running_stats_aggregator_defines.svh"

module running_stats_aggregator import rsa_pkg::*; #(
   parameter int DATA_WIDTH  = DATA_W_DEF,
   parameter int COUNT_WIDTH = COUNT_W_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   // input items
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [2:0]                    req_func,
   input  logic signed [DATA_WIDTH-1:0]  req_sample,
   // result items
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_rejected,
   output logic signed [DATA_WIDTH-1:0]  rsp_minimum,
   output logic signed [DATA_WIDTH-1:0]  rsp_maximum,
   output logic signed [DATA_WIDTH-1:0]  rsp_total,
   output logic [COUNT_WIDTH-1:0]        rsp_sample_count,
   output logic [COUNT_WIDTH-1:0]        rsp_min_seen,
   output logic [COUNT_WIDTH-1:0]        rsp_max_seen,
   output logic signed [DATA_WIDTH-1:0]  rsp_mean,
   output logic [VAR_W-1:0]              rsp_variance_q8,
   output logic                          rsp_variance_valid,
   // configuration write
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic                          csr_variance_enable
);

   localparam logic [DATA_WIDTH-1:0] MEAN_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};

   seq_ctrl_type seq_ctrl;
   seq_stat_type seq_stat;

   logic var_en_ff, var_en_in;
   logic rsp_valid_ff, rsp_valid_in;

   logic                         res_rejected;
   logic signed [DATA_WIDTH-1:0] res_minimum, res_maximum, res_total, res_mean;
   logic [COUNT_WIDTH-1:0]       res_sample_count, res_min_seen, res_max_seen;
   logic [VAR_W-1:0]             res_variance_q8;
   logic                         res_variance_valid;

   logic                         rsp_rejected_ff;
   logic signed [DATA_WIDTH-1:0] rsp_minimum_ff, rsp_maximum_ff, rsp_total_ff, rsp_mean_ff;
   logic [COUNT_WIDTH-1:0]       rsp_sample_count_ff, rsp_min_seen_ff, rsp_max_seen_ff;
   logic [VAR_W-1:0]             rsp_variance_q8_ff;
   logic                         rsp_variance_valid_ff;

   // handshakes: accept only when the sequencer is idle; hand the result
   // over when the output register is empty or being drained
   assign req_stall      = seq_stat.busy;
   assign seq_ctrl.start = req_valid & ~seq_stat.busy;
   assign seq_ctrl.ack   = seq_stat.done & (~rsp_valid_ff | ~rsp_stall);
   // config only between items, never beside an offered item
   assign csr_ready      = ~seq_stat.busy & ~req_valid;

   rsa_seq #(
      .DATA_WIDTH  (DATA_WIDTH),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_seq (
      .clock          (clock),
      .reset          (reset),
      .ctrl           (seq_ctrl),
      .func           (req_func),
      .sample         (req_sample),
      .var_en         (var_en_ff),
      .stat           (seq_stat),
      .rejected       (res_rejected),
      .minimum        (res_minimum),
      .maximum        (res_maximum),
      .total          (res_total),
      .sample_count   (res_sample_count),
      .min_seen       (res_min_seen),
      .max_seen       (res_max_seen),
      .mean           (res_mean),
      .variance_q8    (res_variance_q8),
      .variance_valid (res_variance_valid)
   );

   // configuration register and output valid
   always_comb begin
      var_en_in    = (csr_valid & csr_ready) ? csr_variance_enable : var_en_ff;
      rsp_valid_in = seq_ctrl.ack ? 1'b1 : (rsp_valid_ff & rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         var_en_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         var_en_ff    <= var_en_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // output payload register
   always_ff @(posedge clock) begin
      if (seq_ctrl.ack) begin
         rsp_rejected_ff       <= res_rejected;
         rsp_minimum_ff        <= res_minimum;
         rsp_maximum_ff        <= res_maximum;
         rsp_total_ff          <= res_total;
         rsp_sample_count_ff   <= res_sample_count;
         rsp_min_seen_ff       <= res_min_seen;
         rsp_max_seen_ff       <= res_max_seen;
         rsp_mean_ff           <= res_mean;
         rsp_variance_q8_ff    <= res_variance_q8;
         rsp_variance_valid_ff <= res_variance_valid;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_rejected       = rsp_rejected_ff;
   assign rsp_minimum        = rsp_minimum_ff;
   assign rsp_maximum        = rsp_maximum_ff;
   assign rsp_total          = rsp_total_ff;
   assign rsp_sample_count   = rsp_sample_count_ff;
   assign rsp_min_seen       = rsp_min_seen_ff;
   assign rsp_max_seen       = rsp_max_seen_ff;
   assign rsp_mean           = rsp_mean_ff;
   assign rsp_variance_q8    = rsp_variance_q8_ff;
   assign rsp_variance_valid = rsp_variance_valid_ff;

   // checks
   `RSA_ASSERT(a_accept_starts, (req_valid && !req_stall) |=> seq_stat.busy, "item accepted but sequencer idle")
   `RSA_ASSERT(a_var_valid_count, (rsp_valid && rsp_variance_valid) |-> (rsp_sample_count >= 2), "variance valid with fewer than two samples")
   `RSA_ASSERT(a_var_invalid_max, (rsp_valid && !rsp_variance_valid) |-> (rsp_variance_q8 == VAR_MAX), "invalid variance not saturated")
   `RSA_ASSERT(a_mean_empty, (rsp_valid && rsp_sample_count == 0) |-> (rsp_mean == MEAN_MAX), "empty mean not at maximum")
   `RSA_ASSERT_ANY(a_reset_empty, reset |=> !rsp_valid, "output valid right after reset")

endmodule

[sv/rsa_alu.sv]
// Shared adder/subtractor. On subtract, cout high means no borrow (a >= b).
module rsa_alu import rsa_pkg::*; #(
   parameter int WIDTH = SQ_W + COUNT_W_DEF
) (
   input  logic [WIDTH-1:0] a,
   input  logic [WIDTH-1:0] b,
   input  logic             sub,
   output logic [WIDTH-1:0] res,
   output logic             cout
);

   logic [WIDTH-1:0] b_op;
   logic [WIDTH:0]   total;

   assign b_op  = sub ? ~b : b;
   assign total = {1'b0, a} + {1'b0, b_op} + {{WIDTH{1'b0}}, sub};
   assign res   = total[WIDTH-1:0];
   assign cout  = total[WIDTH];

endmodule

[sv/rsa_seq.sv]
// Statistics state and the sequencer that runs every multiply and divide
// one bit per cycle through the shared adder.
module rsa_seq import rsa_pkg::*; #(
   parameter int DATA_WIDTH  = DATA_W_DEF,
   parameter int COUNT_WIDTH = COUNT_W_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  seq_ctrl_type                  ctrl,
   input  logic [2:0]                    func,
   input  logic signed [DATA_WIDTH-1:0]  sample,
   input  logic                          var_en,
   output seq_stat_type                  stat,
   output logic                          rejected,
   output logic signed [DATA_WIDTH-1:0]  minimum,
   output logic signed [DATA_WIDTH-1:0]  maximum,
   output logic signed [DATA_WIDTH-1:0]  total,
   output logic [COUNT_WIDTH-1:0]        sample_count,
   output logic [COUNT_WIDTH-1:0]        min_seen,
   output logic [COUNT_WIDTH-1:0]        max_seen,
   output logic signed [DATA_WIDTH-1:0]  mean,
   output logic [VAR_W-1:0]              variance_q8,
   output logic                          variance_valid
);

   localparam int DW     = DATA_WIDTH;
   localparam int CW     = COUNT_WIDTH;
   // accumulator holds n * Q exactly; the dividend adds the fraction bits
   localparam int AW     = SQ_W + CW;
   localparam int MW     = AW + FRAC_W;
   localparam int STEP_W = $clog2(MW);
   localparam logic [DW-1:0] MEAN_MAX = {1'b0, {(DW-1){1'b1}}};

   state_type state_ff, state_in;

   // statistics state
   logic signed [DW-1:0] sum_ff, sum_in;
   logic signed [DW-1:0] min_ff, min_in;
   logic signed [DW-1:0] max_ff, max_in;
   logic [SQ_W-1:0]      sq_sum_ff, sq_sum_in;
   logic [CW-1:0]        count_ff, count_in;
   logic [CW-1:0]        min_cnt_ff, min_cnt_in;
   logic [CW-1:0]        max_cnt_ff, max_cnt_in;
   // n * (n - 1), kept up to date on every push
   logic [2*CW-1:0]      pair_ff, pair_in;

   // working registers of the shared unit
   logic [AW-1:0]        acc_ff, acc_in;
   logic [AW-1:0]        mcand_ff, mcand_in;
   logic [MW-1:0]        mplier_ff, mplier_in;
   logic [STEP_W-1:0]    step_ff, step_in;
   logic                 neg_ff, neg_in;

   // result registers
   logic                 rejected_ff, rejected_in;
   logic [DW-1:0]        mean_ff, mean_in;
   logic [VAR_W-1:0]     var_ff, var_in;
   logic                 vvalid_ff, vvalid_in;

   logic [DW-1:0]        sample_abs;
   logic [DW-1:0]        sum_abs;
   logic [DW-1:0]        quot;
   logic                 push_sq;
   logic                 last_step;

   logic [AW-1:0]        alu_a, alu_b, alu_res;
   logic                 alu_sub, alu_cout;

   assign sample_abs = sample[DW-1] ? DW'(-sample) : DW'(sample);
   assign sum_abs    = sum_ff[DW-1] ? DW'(-sum_ff) : DW'(sum_ff);
   assign quot       = mplier_ff[DW-1:0];
   assign last_step  = (step_ff == '0);

   // operand selection: divide states shift the remainder, others add/sub
   always_comb begin
      case (state_ff)
         ST_MEAN, ST_VAR_DIV: begin
            alu_a   = {acc_ff[AW-2:0], mplier_ff[MW-1]};
            alu_b   = mcand_ff;
            alu_sub = 1'b1;
         end
         default: begin
            alu_a   = acc_ff;
            alu_b   = mplier_ff[0] ? mcand_ff : '0;
            alu_sub = (state_ff == ST_SS);
         end
      endcase
   end

   rsa_alu #(
      .WIDTH (AW)
   ) u_alu (
      .a    (alu_a),
      .b    (alu_b),
      .sub  (alu_sub),
      .res  (alu_res),
      .cout (alu_cout)
   );

   // next state and datapath
   always_comb begin
      state_in    = state_ff;
      sum_in      = sum_ff;
      min_in      = min_ff;
      max_in      = max_ff;
      sq_sum_in   = sq_sum_ff;
      count_in    = count_ff;
      min_cnt_in  = min_cnt_ff;
      max_cnt_in  = max_cnt_ff;
      pair_in     = pair_ff;
      acc_in      = acc_ff;
      mcand_in    = mcand_ff;
      mplier_in   = mplier_ff;
      step_in     = step_ff;
      neg_in      = neg_ff;
      rejected_in = rejected_ff;
      mean_in     = mean_ff;
      var_in      = var_ff;
      vvalid_in   = vvalid_ff;
      push_sq     = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            // preload the sample square: acc starts at Q so it ends at Q + x*x
            acc_in    = AW'(sq_sum_ff);
            mcand_in  = AW'(sample_abs);
            mplier_in = MW'(sample_abs);
            step_in   = STEP_W'(DW - 1);
            if (ctrl.start) begin
               rejected_in = 1'b0;
               case (func_type'(func))
                  FUNC_PUSH: begin
                     if (count_ff == '1) begin
                        rejected_in = 1'b1;
                     end else begin
                        sum_in   = sum_ff + sample;
                        count_in = count_ff + CW'(1);
                        pair_in  = pair_ff + (2*CW)'({count_ff, 1'b0});
                        if (sample < min_ff || min_cnt_ff == '0) begin
                           min_in = sample;
                        end
                        if (sample > max_ff || max_cnt_ff == '0) begin
                           max_in = sample;
                        end
                        if (min_cnt_ff != '1) begin
                           min_cnt_in = min_cnt_ff + CW'(1);
                        end
                        if (max_cnt_ff != '1) begin
                           max_cnt_in = max_cnt_ff + CW'(1);
                        end
                        push_sq = var_en;
                     end
                  end
                  FUNC_CLR_MIN: begin
                     min_in     = '0;
                     min_cnt_in = '0;
                  end
                  FUNC_CLR_MAX: begin
                     max_in     = '0;
                     max_cnt_in = '0;
                  end
                  FUNC_CLR_SUM: begin
                     sum_in    = '0;
                     count_in  = '0;
                     sq_sum_in = '0;
                     pair_in   = '0;
                  end
                  FUNC_CLR_ALL: begin
                     min_in     = '0;
                     min_cnt_in = '0;
                     max_in     = '0;
                     max_cnt_in = '0;
                     sum_in     = '0;
                     count_in   = '0;
                     sq_sum_in  = '0;
                     pair_in    = '0;
                  end
                  default: begin
                  end
               endcase
               state_in = push_sq ? ST_SQR : ST_MEAN_PLAN;
            end
         end

         // shift-add square of the sample onto the square sum
         ST_SQR: begin
            acc_in    = alu_res;
            mcand_in  = mcand_ff << 1;
            mplier_in = mplier_ff >> 1;
            step_in   = step_ff - STEP_W'(1);
            if (last_step) begin
               sq_sum_in = alu_res[SQ_W-1:0];
               state_in  = ST_MEAN_PLAN;
            end
         end

         ST_MEAN_PLAN: begin
            if (count_ff == '0) begin
               mean_in  = MEAN_MAX;
               state_in = ST_VAR_PLAN;
            end else begin
               acc_in    = '0;
               mcand_in  = AW'(count_ff);
               mplier_in = {sum_abs, {(MW-DW){1'b0}}};
               step_in   = STEP_W'(DW - 1);
               state_in  = ST_MEAN;
            end
         end

         // restoring division: remainder in acc, quotient shifts into mplier
         ST_MEAN, ST_VAR_DIV: begin
            acc_in    = alu_cout ? alu_res : alu_a;
            mplier_in = {mplier_ff[MW-2:0], alu_cout};
            step_in   = step_ff - STEP_W'(1);
            if (last_step) begin
               state_in = (state_ff == ST_MEAN) ? ST_MEAN_END : ST_VAR_END;
            end
         end

         // quotient of magnitudes, sign restored (truncates toward zero)
         ST_MEAN_END: begin
            mean_in  = sum_ff[DW-1] ? (~quot + DW'(1)) : quot;
            state_in = ST_VAR_PLAN;
         end

         ST_VAR_PLAN: begin
            if (var_en && count_ff >= CW'(2)) begin
               acc_in    = '0;
               mcand_in  = AW'(sq_sum_ff);
               mplier_in = MW'(count_ff);
               step_in   = STEP_W'(CW - 1);
               state_in  = ST_NQ;
            end else begin
               var_in    = VAR_MAX;
               vvalid_in = 1'b0;
               state_in  = ST_DONE;
            end
         end

         // n * Q, then load |S| for the square subtraction
         ST_NQ: begin
            acc_in    = alu_res;
            mcand_in  = mcand_ff << 1;
            mplier_in = mplier_ff >> 1;
            step_in   = step_ff - STEP_W'(1);
            if (last_step) begin
               mcand_in  = AW'(sum_abs);
               mplier_in = MW'(sum_abs);
               step_in   = STEP_W'(DW - 1);
               neg_in    = 1'b0;
               state_in  = ST_SS;
            end
         end

         // n * Q - S * S; any borrow means a negative numerator
         ST_SS: begin
            acc_in    = alu_res;
            mcand_in  = mcand_ff << 1;
            mplier_in = mplier_ff >> 1;
            step_in   = step_ff - STEP_W'(1);
            neg_in    = neg_ff | (mplier_ff[0] & ~alu_cout);
            if (last_step) begin
               state_in = ST_VAR_SETUP;
            end
         end

         ST_VAR_SETUP: begin
            if (neg_ff) begin
               var_in    = '0;
               vvalid_in = 1'b1;
               state_in  = ST_DONE;
            end else begin
               mplier_in = {acc_ff, {FRAC_W{1'b0}}};
               acc_in    = '0;
               mcand_in  = AW'(pair_ff);
               step_in   = STEP_W'(MW - 1);
               state_in  = ST_VAR_DIV;
            end
         end

         // saturate the wide quotient
         ST_VAR_END: begin
            var_in    = (|mplier_ff[MW-1:VAR_W]) ? VAR_MAX : mplier_ff[VAR_W-1:0];
            vvalid_in = 1'b1;
            state_in  = ST_DONE;
         end

         ST_DONE: begin
            if (ctrl.ack) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control and statistics state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         sum_ff     <= '0;
         min_ff     <= '0;
         max_ff     <= '0;
         sq_sum_ff  <= '0;
         count_ff   <= '0;
         min_cnt_ff <= '0;
         max_cnt_ff <= '0;
         pair_ff    <= '0;
      end else begin
         state_ff   <= state_in;
         sum_ff     <= sum_in;
         min_ff     <= min_in;
         max_ff     <= max_in;
         sq_sum_ff  <= sq_sum_in;
         count_ff   <= count_in;
         min_cnt_ff <= min_cnt_in;
         max_cnt_ff <= max_cnt_in;
         pair_ff    <= pair_in;
      end
   end

   // working and result registers
   always_ff @(posedge clock) begin
      acc_ff      <= acc_in;
      mcand_ff    <= mcand_in;
      mplier_ff   <= mplier_in;
      step_ff     <= step_in;
      neg_ff      <= neg_in;
      rejected_ff <= rejected_in;
      mean_ff     <= mean_in;
      var_ff      <= var_in;
      vvalid_ff   <= vvalid_in;
   end

   assign stat.busy      = (state_ff != ST_IDLE);
   assign stat.done      = (state_ff == ST_DONE);
   assign rejected       = rejected_ff;
   assign minimum        = min_ff;
   assign maximum        = max_ff;
   assign total          = sum_ff;
   assign sample_count   = count_ff;
   assign min_seen       = min_cnt_ff;
   assign max_seen       = max_cnt_ff;
   assign mean           = mean_ff;
   assign variance_q8    = var_ff;
   assign variance_valid = vvalid_ff;

endmodule
